// File: hw/rtl/rdpr_pkg.sv
// Shared constants, types and helper functions of the remote-debug packet receiver.
`default_nettype none

package rdpr_pkg;

    localparam int MaxPacketBytes = 4096;
    localparam int CountW = $clog2(MaxPacketBytes);
    localparam logic [CountW-1:0] CountLimit = CountW'(MaxPacketBytes - 1);

    localparam logic [7:0] CharBreak   = 8'h03;
    localparam logic [7:0] CharDollar  = 8'h24;
    localparam logic [7:0] CharPercent = 8'h25;
    localparam logic [7:0] CharHash    = 8'h23;
    localparam logic [7:0] CharBrace   = 8'h7D;
    localparam logic [7:0] CharMinus   = 8'h2D;

    typedef enum logic [2:0] {
        EV_PAYLOAD = 3'd0,
        EV_GOOD    = 3'd1,
        EV_BAD     = 3'd2,
        EV_BREAK   = 3'd3,
        EV_RESEND  = 3'd4,
        EV_ERROR   = 3'd5
    } event_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_LOW  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    // A byte that is not a hex digit decodes to zero with ok cleared.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.value = 4'(c - 8'h37);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rdpr_byte_if.sv
// Channel that carries received serial bytes into the receiver.
`default_nettype none

interface rdpr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rdpr_event_if.sv
// Channel that carries framing events out of the receiver.
`default_nettype none

interface rdpr_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  computed_sum;
    logic [11:0] payload_length;
    logic        is_notification;

    modport source (output valid, output event_res, output data_byte, output computed_sum,
                    output payload_length, output is_notification, input ready);
    modport sink   (input valid, input event_res, input data_byte, input computed_sum,
                    input payload_length, input is_notification, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/remote_debug_packet_receiver_top.sv
// Top level of the remote-debug packet receiver: framing state and event output.
//
// The receiver takes one serial byte per transaction on byte_in and gives at most
// one event per byte on event_out: a payload byte, a packet verdict (good or bad,
// with the received checksum, the computed sum and the payload length), a break
// request, a resend request or a framing error. Bytes that only change the framing
// state (packet openers, ignored bytes, the terminator) give no event.
// A byte is held in an input register; the framing update and the event decode
// run combinationally from there into the output register. An event is presented
// on event_out once its byte has passed the input register and then the output
// register. A byte can be accepted every cycle while the event sink does not stall,
// so the sustained rate is then one byte per cycle.
// Reset clears the framing state to idle and empties both registers.
// When the event sink stalls, the output register holds its event and the input
// register still takes one more byte; bytes that give no event keep flowing only
// once the output register drains, and byte_in.ready falls while both are full.
`default_nettype none

module remote_debug_packet_receiver_top (
    input  wire              clk,
    input  wire              rst_n,
    rdpr_byte_if.sink        byte_in,
    rdpr_event_if.source     event_out
);
    import rdpr_pkg::*;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;

    phase_t            phase_reg, phase_next;
    logic [7:0]        sum_reg, sum_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [3:0]        high_digit_reg, high_digit_next;
    logic              high_ok_reg, high_ok_next;
    logic              unframed_reg, unframed_next;
    logic              note_reg, note_next;

    logic              out_valid_reg;
    event_t            out_event_reg;
    logic [7:0]        out_data_reg;
    logic [7:0]        out_sum_reg;
    logic [11:0]       out_len_reg;
    logic              out_note_reg;

    logic              out_free;
    logic              advance;
    logic              emit;
    event_t            ev;
    logic [7:0]        ev_data;
    logic [7:0]        ev_sum;
    logic [11:0]       ev_len;
    logic              ev_note;
    hex_digit_t        digit;
    logic [7:0]        got;

    assign out_free      = !out_valid_reg || event_out.ready;
    assign advance       = in_valid_reg && out_free;
    assign byte_in.ready = !in_valid_reg || advance;

    assign digit      = hex_decode(in_byte_reg);
    assign got        = {high_digit_reg, digit.value};

    always_comb
    begin
        phase_next      = phase_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        high_digit_next = high_digit_reg;
        high_ok_next    = high_ok_reg;
        unframed_next   = unframed_reg;
        note_next       = note_reg;
        emit            = 1'b0;
        ev              = EV_ERROR;
        ev_data         = 8'd0;
        ev_sum          = 8'd0;
        ev_len          = 12'd0;
        ev_note         = 1'b0;

        if (in_byte_reg == CharBrace)
        begin
            phase_next    = PH_IDLE;
            unframed_next = 1'b0;
            emit          = 1'b1;
            ev            = EV_ERROR;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte_reg == CharDollar || in_byte_reg == CharPercent)
                    begin
                        sum_next      = 8'd0;
                        count_next    = '0;
                        note_next     = (in_byte_reg == CharPercent);
                        unframed_next = 1'b0;
                        phase_next    = PH_BODY;
                    end
                    else if (in_byte_reg == CharBreak)
                    begin
                        emit = 1'b1;
                        ev   = EV_BREAK;
                    end
                    else if (in_byte_reg == CharMinus)
                    begin
                        emit = 1'b1;
                        ev   = EV_RESEND;
                    end
                    else if (in_byte_reg == CharHash)
                    begin
                        // A terminator with no opener still consumes two digits.
                        sum_next      = 8'd0;
                        count_next    = '0;
                        note_next     = 1'b0;
                        unframed_next = 1'b1;
                        phase_next    = PH_HIGH;
                    end
                end
                PH_BODY:
                begin
                    if (in_byte_reg == CharBreak)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (in_byte_reg == CharDollar)
                    begin
                        sum_next      = 8'd0;
                        count_next    = '0;
                        note_next     = 1'b0;
                        unframed_next = 1'b0;
                    end
                    else if (in_byte_reg == CharHash)
                    begin
                        phase_next = PH_HIGH;
                    end
                    else if (count_reg == CountLimit)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        ev         = EV_ERROR;
                    end
                    else
                    begin
                        sum_next   = sum_reg + in_byte_reg;
                        count_next = count_reg + 1'b1;
                        emit       = 1'b1;
                        ev         = EV_PAYLOAD;
                        ev_data    = in_byte_reg;
                        ev_note    = note_reg;
                    end
                end
                PH_HIGH:
                begin
                    high_digit_next = digit.value;
                    high_ok_next    = digit.ok;
                    phase_next      = PH_LOW;
                end
                PH_LOW:
                begin
                    emit = 1'b1;
                    if (!unframed_reg && high_ok_reg && digit.ok && got == sum_reg)
                    begin
                        ev = EV_GOOD;
                    end
                    else
                    begin
                        ev = EV_BAD;
                    end
                    ev_data       = got;
                    ev_sum        = sum_reg;
                    ev_len        = 12'(count_reg);
                    ev_note       = note_reg;
                    phase_next    = PH_IDLE;
                    unframed_next = 1'b0;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            sum_reg        <= 8'd0;
            count_reg      <= '0;
            high_digit_reg <= 4'd0;
            high_ok_reg    <= 1'b0;
            unframed_reg   <= 1'b0;
            note_reg       <= 1'b0;
        end
        else
        begin
            if (byte_in.ready)
            begin
                in_valid_reg <= byte_in.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && emit;
            end
            if (advance)
            begin
                phase_reg      <= phase_next;
                sum_reg        <= sum_next;
                count_reg      <= count_next;
                high_digit_reg <= high_digit_next;
                high_ok_reg    <= high_ok_next;
                unframed_reg   <= unframed_next;
                note_reg       <= note_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.rx_byte;
        end
        if (advance && emit)
        begin
            out_event_reg <= ev;
            out_data_reg  <= ev_data;
            out_sum_reg   <= ev_sum;
            out_len_reg   <= ev_len;
            out_note_reg  <= ev_note;
        end
    end

    assign event_out.valid           = out_valid_reg;
    assign event_out.event_res       = out_event_reg;
    assign event_out.data_byte       = out_data_reg;
    assign event_out.computed_sum    = out_sum_reg;
    assign event_out.payload_length  = out_len_reg;
    assign event_out.is_notification = out_note_reg;

    // A good verdict always carries a checksum equal to the computed sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg == EV_GOOD) |-> (out_data_reg == out_sum_reg))
    else $error("good verdict with mismatching checksum");

    // The payload count never passes the largest legal packet size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountLimit)
    else $error("payload count beyond packet limit");

    // A $ packet opener seen while idle leads into the packet body with the count cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_IDLE && in_byte_reg == CharDollar)
        |=> (phase_reg == PH_BODY && count_reg == '0))
    else $error("packet opener did not enter the body");

endmodule

`default_nettype wire
